// File: design/tcse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcse_pkg;

	localparam logic [31:0] ERR_VALUE = 32'h8000_0001;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = 3;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	// code word tags, low two bits
	localparam logic [1:0] TAG_CALL = 2'b00;
	localparam logic [1:0] TAG_ADDR = 2'b01;
	localparam logic [1:0] TAG_INT  = 2'b10;
	localparam logic [1:0] TAG_CODE = 2'b11;

	// codes in bits 4:2 of a tag-11 word
	localparam logic [2:0] CODE_PUSHINT = 3'd0;
	localparam logic [2:0] CODE_IF      = 3'd1;
	localparam logic [2:0] CODE_ELSE    = 3'd2;
	localparam logic [2:0] CODE_DONE    = 3'd3;

	typedef enum logic [2:0] {
		ACT_EXEC   = 3'd0,
		ACT_PUSH   = 3'd1,
		ACT_POP    = 3'd2,
		ACT_PEEK   = 3'd3,
		ACT_SETTOP = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_RANGE     = 2'd3
	} err_t;

	// classified operation, decided by the front end
	typedef enum logic [3:0] {
		K_CALL  = 4'd0,
		K_PUSHW = 4'd1,
		K_LIT   = 4'd2,
		K_IF    = 4'd3,
		K_ELSE  = 4'd4,
		K_DONE  = 4'd5,
		K_NOP   = 4'd6,
		K_HPUSH = 4'd7,
		K_HPOP  = 4'd8,
		K_HPEEK = 4'd9,
		K_HSET  = 4'd10,
		K_HNONE = 4'd11
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        exec;
		logic [31:0] word;
		logic [31:0] data;
		logic [4:0]  peek_index;
		logic [26:0] skip_n;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

// File: design/threaded_code_stack_executor.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                                   tuser
// s_axis    in   code_word, operand_value, peek_index    action
// m_axis    out  read_value, stack_depth, error_code,    call_request, program_done,
//                call_word                               word_skipped
//
// one item per cycle sustained while m_axis takes results; m_axis_tvalid for an item
// rises after its input transfer passes queue write, execute with stack memory access
// and output register; an IF's zero test is taken from the stack memory read register in
// the cycle after the IF, in time for the next code word, so branches add no bubble
// reset clears depth, skip count and literal mark; stack memory is not cleared, no sweep
// s_axis_tready drops only when the four-entry queue is full; m_axis stalls back up
// the execute stage, never the input side until the queue fills

module threaded_code_stack_executor #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [31:0] code_word, [63:32] operand_value, [68:64] peek_index, [71:69] zero
	input  wire logic [tcse_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [2:0] action
	input  wire logic [2:0]                       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [31:0] read_value, [37:32] stack_depth, [39:38] error_code, [71:40] call_word
	output logic [tcse_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// [0] call_request, [1] program_done, [2] word_skipped
	output logic [2:0]                            m_axis_tuser
);

	// front end to queue
	logic                q_push;
	tcse_pkg::item_t     q_item;
	// queue to back end
	tcse_pkg::item_t     q_head;
	tcse_pkg::q_status_t q_stat;
	logic                q_pop;
	// current stack depth, full width
	logic [$clog2(STACK_DEPTH+1)-1:0] depth_cnt;

	// decode action, tag and code into an operation kind
	tcse_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_stat       (q_stat),
		.push         (q_push),
		.item         (q_item)
	);

	// short queue decoupling intake from execution
	tcse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.item_in(q_item),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	// stack state, skip and literal tracking, stack memory and result register
	tcse_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_stat       (q_stat),
		.pop          (q_pop),
		.depth_cnt    (depth_cnt),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

`ifndef SYNTHESIS
	// queue is never written while full
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_stat.full)
		else $error("queue written while full");

	// queue is never read while empty
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	// stack depth stays within the memory
	assert property (@(posedge clk) disable iff (!arst_n) depth_cnt <= STACK_DEPTH)
		else $error("stack depth beyond capacity");

	// call, done and skip are exclusive outcomes of one item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tuser))
		else $error("more than one outcome flag set");

	// a skipped word reports no error
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata[39:38] == tcse_pkg::ERR_NONE))
		else $error("skipped word carries an error");
`endif

endmodule

`default_nettype wire

// File: design/tcse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/tcse_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcse_front (
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [tcse_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  wire logic [2:0]                         s_axis_tuser,
	input  wire tcse_pkg::q_status_t                q_stat,
	output logic                                    push,
	output tcse_pkg::item_t                         item
);

	logic [31:0]       word;
	tcse_pkg::action_t act;

	assign word          = s_axis_tdata[31:0];
	assign act           = tcse_pkg::action_t'(s_axis_tuser);
	assign s_axis_tready = !q_stat.full;
	assign push          = s_axis_tvalid && !q_stat.full;

	always_comb begin
		item.kind       = tcse_pkg::K_HNONE;
		item.exec       = 1'b0;
		item.word       = word;
		item.data       = s_axis_tdata[63:32];
		item.peek_index = s_axis_tdata[68:64];
		item.skip_n     = word[31:5];
		case (act)
			tcse_pkg::ACT_EXEC: begin
				item.exec = 1'b1;
				case (word[1:0])
					tcse_pkg::TAG_CALL: item.kind = tcse_pkg::K_CALL;
					tcse_pkg::TAG_ADDR: begin
						item.kind = tcse_pkg::K_PUSHW;
						item.data = {word[31:2], 2'b00};
					end
					tcse_pkg::TAG_INT: begin
						item.kind = tcse_pkg::K_PUSHW;
						item.data = {{2{word[31]}}, word[31:2]};
					end
					default: begin
						case (word[4:2])
							tcse_pkg::CODE_PUSHINT: item.kind = tcse_pkg::K_LIT;
							tcse_pkg::CODE_IF:      item.kind = tcse_pkg::K_IF;
							tcse_pkg::CODE_ELSE:    item.kind = tcse_pkg::K_ELSE;
							tcse_pkg::CODE_DONE:    item.kind = tcse_pkg::K_DONE;
							default:                item.kind = tcse_pkg::K_NOP;
						endcase
					end
				endcase
			end
			tcse_pkg::ACT_PUSH:   item.kind = tcse_pkg::K_HPUSH;
			tcse_pkg::ACT_POP:    item.kind = tcse_pkg::K_HPOP;
			tcse_pkg::ACT_PEEK:   item.kind = tcse_pkg::K_HPEEK;
			tcse_pkg::ACT_SETTOP: item.kind = tcse_pkg::K_HSET;
			default:              item.kind = tcse_pkg::K_HNONE;
		endcase
	end

endmodule

`default_nettype wire

// File: design/tcse_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tcse_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tcse_pkg::item_t item_in,
	input  wire logic            pop,
	output tcse_pkg::item_t      head,
	output tcse_pkg::q_status_t  stat
);

	tcse_pkg::item_t                 mem_q [tcse_pkg::QUEUE_DEPTH];
	logic [tcse_pkg::QUEUE_AW-1:0]   wr_q;
	logic [tcse_pkg::QUEUE_AW-1:0]   rd_q;
	logic [tcse_pkg::QUEUE_CW-1:0]   cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == tcse_pkg::QUEUE_CW'(tcse_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + tcse_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + tcse_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + tcse_pkg::QUEUE_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - tcse_pkg::QUEUE_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

endmodule

`default_nettype wire

// File: design/tcse_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcse_back #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tcse_pkg::item_t                      head,
	input  wire tcse_pkg::q_status_t                  q_stat,
	output logic                                      pop,
	output logic [$clog2(STACK_DEPTH+1)-1:0]          depth_cnt,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic [tcse_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
	output logic [2:0]                                m_axis_tuser
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	typedef struct packed {
		logic [31:0]    read_value;
		logic           use_ram;
		logic [5:0]     depth;
		tcse_pkg::err_t err;
		logic [31:0]    call_word;
		logic           call_req;
		logic           done;
		logic           skipped;
	} res_t;

	logic [CW-1:0]    count_q;
	logic [26:0]      skip_q;
	logic             lit_q;
	logic             if_live_q;
	logic [26:0]      if_n_q;
	logic             valid_s1;
	res_t             res_s1;
	logic             m_tvalid_q;
	logic [tcse_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [2:0]       m_tuser_q;

	logic             fire;
	logic             s1_ready;
	logic             out_ready;
	logic             full;
	logic             empty;
	logic [CW-1:0]    cm1;
	logic             peek_ok;
	logic [CW+4:0]    peek_diff;
	logic [26:0]      skip_eff;
	logic [26:0]      skip_nx;
	logic [CW-1:0]    count_nx;
	logic             lit_nx;
	logic             if_arm;
	logic             push_req;
	logic [31:0]      push_val;
	logic             pop_req;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [31:0]      ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [31:0]      ram_rdata;
	logic [31:0]      rv_out;
	res_t             res;

	assign out_ready = !m_tvalid_q || m_axis_tready;
	assign s1_ready  = !valid_s1 || out_ready;
	assign fire      = !q_stat.empty && s1_ready;
	assign pop       = fire;
	assign depth_cnt = count_q;

	assign full      = (count_q == CW'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign cm1       = count_q - CW'(1);
	assign peek_ok   = {5'b0, count_q} > {{CW{1'b0}}, head.peek_index};
	assign peek_diff = {5'b0, cm1} - {{CW{1'b0}}, head.peek_index};

	// an IF popped last cycle: its value is in the read register now
	assign skip_eff = if_live_q ? ((ram_rdata == '0) ? if_n_q : '0) : skip_q;

	always_comb begin
		push_req  = 1'b0;
		push_val  = head.data;
		pop_req   = 1'b0;
		if_arm    = 1'b0;
		count_nx  = count_q;
		skip_nx   = skip_eff;
		lit_nx    = lit_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = head.data;
		ram_raddr = cm1[AW-1:0];
		res       = '0;
		if (head.exec) begin
			if (lit_q) begin
				lit_nx   = 1'b0;
				push_req = 1'b1;
				push_val = head.word;
			end else if (skip_eff != '0) begin
				skip_nx     = skip_eff - 27'd1;
				res.skipped = 1'b1;
			end else begin
				case (head.kind)
					tcse_pkg::K_CALL: begin
						res.call_req  = 1'b1;
						res.call_word = head.word;
					end
					tcse_pkg::K_PUSHW: push_req = 1'b1;
					tcse_pkg::K_LIT:   lit_nx = 1'b1;
					tcse_pkg::K_IF: begin
						pop_req = 1'b1;
						if_arm  = !empty;
					end
					tcse_pkg::K_ELSE:  skip_nx = head.skip_n;
					tcse_pkg::K_DONE:  res.done = 1'b1;
					default: ;
				endcase
			end
		end else begin
			case (head.kind)
				tcse_pkg::K_HPUSH: push_req = 1'b1;
				tcse_pkg::K_HPOP:  pop_req = 1'b1;
				tcse_pkg::K_HPEEK: begin
					if (peek_ok) begin
						ram_raddr   = peek_diff[AW-1:0];
						res.use_ram = 1'b1;
					end else begin
						res.read_value = tcse_pkg::ERR_VALUE;
						res.err        = tcse_pkg::ERR_RANGE;
					end
				end
				tcse_pkg::K_HSET: begin
					if (empty) begin
						res.err = tcse_pkg::ERR_UNDERFLOW;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = cm1[AW-1:0];
						ram_wdata = head.data;
					end
				end
				default: ;
			endcase
		end
		if (push_req) begin
			if (full) begin
				res.err = tcse_pkg::ERR_OVERFLOW;
			end else begin
				ram_we    = 1'b1;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = push_val;
				count_nx  = count_q + CW'(1);
			end
		end
		if (pop_req) begin
			if (empty) begin
				res.err        = tcse_pkg::ERR_UNDERFLOW;
				res.read_value = tcse_pkg::ERR_VALUE;
			end else begin
				count_nx    = cm1;
				ram_raddr   = cm1[AW-1:0];
				res.use_ram = 1'b1;
			end
		end
		res.depth = 6'(count_nx);
	end

	tcse_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we && fire),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (fire),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rv_out = res_s1.use_ram ? ram_rdata : res_s1.read_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			skip_q     <= '0;
			lit_q      <= 1'b0;
			if_live_q  <= 1'b0;
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_nx;
				lit_q   <= lit_nx;
			end
			skip_q    <= fire ? skip_nx : skip_eff;
			if_live_q <= fire && if_arm;
			if (s1_ready) begin
				valid_s1 <= fire;
			end
			if (out_ready) begin
				m_tvalid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
		if (fire && if_arm) begin
			if_n_q <= head.skip_n;
		end
		if (valid_s1 && out_ready) begin
			m_tdata_q <= {res_s1.call_word, res_s1.err, res_s1.depth, rv_out};
			m_tuser_q <= {res_s1.skipped, res_s1.done, res_s1.call_req};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// File: tb/sv/tcse_tb_pkg.sv
`timescale 1ns / 1ps

package tcse_tb_pkg;

	import tcse_pkg::*;

	localparam int STACK_ENTRIES = 32;

	// one result transfer, laid out as {m_axis_tuser, m_axis_tdata}
	typedef struct packed {
		logic        word_skipped;
		logic        program_done;
		logic        call_request;
		logic [31:0] call_word;
		err_t        error_code;
		logic [5:0]  stack_depth;
		logic [31:0] read_value;
	} result_t;

	class stack_tracker;
		logic [31:0] entries [STACK_ENTRIES];
		int unsigned depth;
		logic [26:0] skip_left;
		bit          literal_next;
		result_t     expected_results [$];
		int          mismatches;
		int          results_checked;
		int          calls, dones, skipped_words;
		int          overflows, underflows, peek_misses, peak_depth;

		function new();
			foreach (entries[i]) entries[i] = '0;
			depth = 0;
			skip_left = '0;
			literal_next = 1'b0;
			mismatches = 0;
			results_checked = 0;
			calls = 0;
			dones = 0;
			skipped_words = 0;
			overflows = 0;
			underflows = 0;
			peek_misses = 0;
			peak_depth = 0;
		endfunction

		function err_t push_entry(logic [31:0] v);
			if (depth >= STACK_ENTRIES) return ERR_OVERFLOW;
			entries[depth] = v;
			depth++;
			if (depth > peak_depth) peak_depth = depth;
			return ERR_NONE;
		endfunction

		function err_t pop_entry(output logic [31:0] v);
			if (depth == 0) begin
				v = ERR_VALUE;
				return ERR_UNDERFLOW;
			end
			depth--;
			v = entries[depth];
			return ERR_NONE;
		endfunction

		// advance the stack machine by one accepted item and queue its result
		function void accept_item(logic [2:0] act, logic [31:0] w, logic [31:0] opv,
				logic [4:0] pidx);
			result_t r;
			r = '0;
			case (act)
			ACT_EXEC: begin
				if (literal_next) begin
					// word after PushInt goes on the stack whole
					literal_next = 1'b0;
					r.error_code = push_entry(w);
				end else if (skip_left != 0) begin
					skip_left--;
					r.word_skipped = 1'b1;
				end else begin
					case (w[1:0])
					TAG_CALL: begin
						r.call_request = 1'b1;
						r.call_word = w;
					end
					TAG_ADDR: r.error_code = push_entry({w[31:2], 2'b00});
					TAG_INT:  r.error_code = push_entry({{2{w[31]}}, w[31:2]});
					default: begin
						case (w[4:2])
						CODE_PUSHINT: literal_next = 1'b1;
						CODE_IF: begin
							// underflow reads the error value, which is nonzero
							r.error_code = pop_entry(r.read_value);
							if (r.read_value == 0) skip_left = w[31:5];
						end
						CODE_ELSE: skip_left = w[31:5];
						CODE_DONE: r.program_done = 1'b1;
						default: ;
						endcase
					end
					endcase
				end
			end
			ACT_PUSH: r.error_code = push_entry(opv);
			ACT_POP:  r.error_code = pop_entry(r.read_value);
			ACT_PEEK: begin
				if (pidx < depth) begin
					r.read_value = entries[depth - 1 - pidx];
				end else begin
					r.read_value = ERR_VALUE;
					r.error_code = ERR_RANGE;
				end
			end
			ACT_SETTOP: begin
				if (depth != 0) entries[depth - 1] = opv;
				else r.error_code = ERR_UNDERFLOW;
			end
			default: ;
			endcase
			r.stack_depth = 6'(depth);
			calls += r.call_request;
			dones += r.program_done;
			skipped_words += r.word_skipped;
			overflows += (r.error_code == ERR_OVERFLOW);
			underflows += (r.error_code == ERR_UNDERFLOW);
			peek_misses += (r.error_code == ERR_RANGE);
			expected_results.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 100) $display("%0t: mismatch: %s", $time, what);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				report($sformatf("result %0d %s: got %h, expected %h",
					results_checked, name, got, want));
			end
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result %h arrived with nothing expected", got));
				return;
			end
			want = expected_results.pop_front();
			compare_field("read_value", got.read_value, want.read_value);
			compare_field("stack_depth", 32'(got.stack_depth), 32'(want.stack_depth));
			compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
			compare_field("call_word", got.call_word, want.call_word);
			compare_field("call_request", 32'(got.call_request), 32'(want.call_request));
			compare_field("program_done", 32'(got.program_done), 32'(want.program_done));
			compare_field("word_skipped", 32'(got.word_skipped), 32'(want.word_skipped));
			results_checked++;
		endtask

		function int pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import tcse_pkg::*;
	import tcse_tb_pkg::*;

	// items per idling phase
	localparam int PHASE_ITEMS = 500;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [31:0] code_word, [63:32] operand_value, [68:64] peek_index, [71:69] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// [2:0] action
	logic [2:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [31:0] read_value, [37:32] stack_depth, [39:38] error_code, [71:40] call_word
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// [0] call_request, [1] program_done, [2] word_skipped
	logic [2:0]            m_axis_tuser;

	stack_tracker tracker;
	int sender_idle_pct = 9;
	int receiver_idle_pct = 76;
	int items_sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	threaded_code_stack_executor #(
		.STACK_DEPTH(STACK_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// result side: check every transfer, then pick the next ready at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.check_result(result_t'({m_axis_tuser, m_axis_tdata}));
		end
		m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send(input logic [2:0] act, input logic [31:0] w, input logic [31:0] opv,
			input logic [4:0] pidx);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, pidx, opv, w};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.accept_item(act, w, opv, pidx);
		if (act <= ACT_SETTOP) items_sent++;
	endtask

	// code word with the fields that it does not use left random
	task automatic exec(input logic [31:0] w);
		send(ACT_EXEC, w, $urandom, 5'($urandom));
	endtask

	function automatic logic [31:0] code_word(input logic [2:0] code, input logic [26:0] n);
		return {n, code, TAG_CODE};
	endfunction

	// any code word, but IF and ELSE only with short skips so the program keeps running
	function automatic logic [31:0] body_word();
		logic [31:0] w;
		w = $urandom;
		if (w[1:0] == TAG_CODE && (w[4:2] == CODE_IF || w[4:2] == CODE_ELSE)) begin
			w[31:5] = 27'($urandom_range(3));
		end
		return w;
	endfunction

	// mostly an entry that exists, sometimes any index
	function automatic logic [4:0] pick_index();
		if (tracker.depth != 0 && $urandom_range(3) != 0) begin
			return 5'($urandom_range(tracker.depth - 1));
		end
		return 5'($urandom);
	endfunction

	// branch followed by its body; IF often gets a zero to test
	task automatic branch_run(input logic [2:0] code);
		int n;
		if (code == CODE_IF && $urandom_range(1) == 1) begin
			send(ACT_PUSH, $urandom, ($urandom_range(1) == 1) ? 32'd0 : $urandom, 5'($urandom));
		end
		n = $urandom_range(4);
		exec(code_word(code, 27'(n)));
		repeat (n + 1) exec(body_word());
	endtask

	// mode 0 fills the stack, mode 1 drains it, mode 2 stays balanced
	task automatic random_item(input int mode);
		int push_cut, pop_cut, r, s;
		logic [31:0] w;
		push_cut = (mode == 0) ? 45 : (mode == 1) ? 10 : 25;
		pop_cut = push_cut + ((mode == 0) ? 10 : (mode == 1) ? 40 : 25);
		r = $urandom_range(99);
		w = $urandom;
		if (r < push_cut) begin
			case ($urandom_range(3))
			0: send(ACT_PUSH, $urandom, w, 5'($urandom));
			1: exec({w[31:2], TAG_ADDR});
			2: exec({w[31:2], TAG_INT});
			default: begin
				// literal, sometimes with a host transfer in between
				exec(code_word(CODE_PUSHINT, 27'($urandom)));
				if ($urandom_range(3) == 0) send(ACT_PEEK, $urandom, $urandom, pick_index());
				exec(w);
			end
			endcase
		end else if (r < pop_cut) begin
			if ($urandom_range(1) == 1) send(ACT_POP, $urandom, $urandom, 5'($urandom));
			else exec(code_word(CODE_IF, 27'($urandom_range(2))));
		end else begin
			s = $urandom_range(99);
			if (s < 25) send(ACT_PEEK, $urandom, $urandom, pick_index());
			else if (s < 40) send(ACT_SETTOP, $urandom, w, 5'($urandom));
			else if (s < 60) branch_run(CODE_IF);
			else if (s < 68) branch_run(CODE_ELSE);
			else if (s < 78) exec({w[31:2], TAG_CALL});
			else if (s < 84) exec(code_word(CODE_DONE, 27'($urandom)));
			else if (s < 94) exec(body_word());
			else if (s < 97) exec(code_word(3'($urandom_range(7, int'(CODE_DONE) + 1)),
				27'($urandom)));
			else send(3'($urandom_range(7, int'(ACT_SETTOP) + 1)), $urandom, $urandom,
				5'($urandom));
		end
	endtask

	// a stretch of items in one stack mode
	task automatic random_item_run(input int mode);
		repeat (40) random_item(mode);
	endtask

	// hold the input side until every expected result has been seen
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack: pop, set top, peek and IF all underflow or miss
		send(ACT_POP, 32'h0, 32'h0, 5'd0);
		send(ACT_SETTOP, 32'h0, 32'hffff_ffff, 5'd0);
		send(ACT_PEEK, 32'h0, 32'h0, 5'd0);
		exec(code_word(CODE_IF, 27'd3));
		// host push of the signed extremes, peeks in and out of range
		send(ACT_PUSH, 32'h0, 32'h7fff_ffff, 5'd0);
		send(ACT_PUSH, 32'h0, 32'h8000_0000, 5'd0);
		send(ACT_PEEK, 32'h0, 32'h0, 5'd0);
		send(ACT_PEEK, 32'h0, 32'h0, 5'd1);
		send(ACT_PEEK, 32'h0, 32'h0, 5'd31);
		send(ACT_SETTOP, 32'h0, 32'h0, 5'd0);
		// pushes from tagged words: cleared tag, sign extension both ways
		exec(32'hffff_ffff & ~32'h2);
		exec({30'h2000_0000, TAG_INT});
		exec({30'h1fff_ffff, TAG_INT});
		// literal survives a host push in between and goes on whole
		exec(code_word(CODE_PUSHINT, '0));
		send(ACT_PUSH, 32'h0, 32'h1, 5'd0);
		exec(32'hffff_ffff);
		exec({30'h3fff_ffff, TAG_CALL});
		exec(code_word(CODE_DONE, '1));
		exec(code_word(CODE_DONE + 3'd1, '0));
		// branch of zero skips nothing
		exec(code_word(CODE_ELSE, '0));
		// zero test taken: a skipped PushInt and its literal both count down
		send(ACT_PUSH, 32'h0, 32'h0, 5'd0);
		exec(code_word(CODE_IF, 27'd2));
		exec(code_word(CODE_PUSHINT, '0));
		exec({30'h1, TAG_ADDR});
		exec({30'h4, TAG_ADDR});
		send(ACT_PUSH, 32'h0, 32'h0, 5'd0);
		exec(code_word(CODE_IF, '0));

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				sender_idle_pct = 76;
				receiver_idle_pct = 9;
			end else if (phase == 2) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			while (items_sent < (phase + 1) * PHASE_ITEMS) begin
				random_item_run($urandom_range(2));
			end
			drain_results();
		end

		// room for anything the block might still send
		repeat (16) @(posedge clk);
		if (tracker.pending() != 0) tracker.report("expected results left over");
		$display("%0d input transfers, %0d results checked, peak depth %0d",
			items_sent, tracker.results_checked, tracker.peak_depth);
		$display("calls %0d, done %0d, skipped %0d, overflow %0d, underflow %0d, peek miss %0d",
			tracker.calls, tracker.dones, tracker.skipped_words, tracker.overflows,
			tracker.underflows, tracker.peek_misses);
		if (tracker.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
